/* rtl/rrs_pkg.sv */
package rrs_pkg;

	// operation codes
	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_START  = 3'd1;
	localparam logic [2:0] OP_TICK   = 3'd2;
	localparam logic [2:0] OP_YIELD  = 3'd3;
	localparam logic [2:0] OP_EXIT   = 3'd4;
	localparam logic [2:0] OP_SWITCH = 3'd5;
	localparam logic [2:0] OP_WAIT   = 3'd6;

	// result status codes
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_NO_FREE   = 3'd1;
	localparam logic [2:0] STAT_NO_TASKS  = 3'd2;
	localparam logic [2:0] STAT_IGNORED   = 3'd3;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

	// slot states
	localparam logic [1:0] SL_UNUSED   = 2'd0;
	localparam logic [1:0] SL_RUNNABLE = 2'd1;
	localparam logic [1:0] SL_ZOMBIE   = 2'd2;

	// register map
	localparam logic REG_RESCHED_PERIOD = 1'b0;
	localparam logic [7:0] RESCHED_PERIOD_RESET = 8'd10;

	typedef struct packed {
		logic [1:0]  state;
		logic [15:0] pid;
		logic [31:0] ret_val;
		logic [31:0] sp;
	} slot_entry_t;

endpackage

/* rtl/round_robin_task_scheduler.sv */
// Round-robin task scheduler over a slot table held in a one-port RAM.
//
// Command channel: operation, stack_pointer, exit_value and target_pid are
// taken at the clock edge where start is high and busy is low. busy stays
// high while the sequencer works on the word; one word at a time.
// Result channel: done is high for exactly one cycle with status, new_pid,
// resume_pointer, reaped_exit and switch_request valid in that cycle. The
// receiver cannot stall it. running_slot and in_kernel always show the
// current context and change on the edge that raises done.
// Config: APB write of resched_period at byte address 0; pready is tied high.
//
// Path from accept to done (done rises on the same edge that drops busy):
//   start, tick, yield, ignored ops: dispatch; exit: dispatch, table write
//   add: dispatch + slots scanned (first free slot, up to NUM_SLOTS)
//   wait: dispatch + slots scanned up to high water
//   switch: dispatch, save write (task), decide + round-robin scan to high water
// Each scanned slot takes one RAM read; the table RAM port sets the rate.
// Reset: the slot table reads as all unused at once through per-slot valid
// flags, so no clearing pass is needed and start may be issued right away.
module round_robin_task_scheduler #(
	parameter int NUM_SLOTS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	// APB config
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// command
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         operation,
	input  logic [31:0]        stack_pointer,
	input  logic signed [31:0] exit_value,
	input  logic [15:0]        target_pid,
	// result
	output logic               done,
	output logic [2:0]         status,
	output logic [15:0]        new_pid,
	output logic [31:0]        resume_pointer,
	output logic signed [31:0] reaped_exit,
	output logic               switch_request,
	output logic [1:0]         running_slot,
	output logic               in_kernel
);
	import rrs_pkg::*;

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int CNT_W  = SLOT_W + 1;    // holds 0..NUM_SLOTS
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_ADD_CHK,
		S_EXIT_WR,
		S_SAVE_WR,
		S_SW_DECIDE,
		S_SW_CHK,
		S_WAIT_CHK
	} seq_state_t;

	seq_state_t state_q;

	// latched command word
	logic [2:0]  op_q;
	logic [31:0] sp_q;
	logic [31:0] code_q;
	logic [15:0] pid_q;

	// scheduler state outside the table
	logic [31:0]       ksp_q;
	logic [CNT_W-1:0]  hw_q;
	logic [CNT_W-1:0]  active_q;
	logic [SLOT_W-1:0] cur_q;
	logic              kernel_q;
	logic              enabled_q;
	logic              pending_q;
	logic [15:0]       pid_ctr_q;
	logic [7:0]        tick_q;
	logic [7:0]        period_q;

	// scan state
	logic [SLOT_W-1:0] scan_idx_q;
	logic [CNT_W-1:0]  scan_cnt_q;

	// result registers
	logic              done_q;
	logic [2:0]        status_q;
	logic [15:0]       new_pid_q;
	logic [31:0]       resume_q;
	logic [31:0]       reaped_q;
	logic              req_q;

	// table port
	logic              mem_en;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_addr;
	slot_entry_t       mem_wdata;
	slot_entry_t       rd;

	rrs_slot_table #(
		.NUM_SLOTS(NUM_SLOTS),
		.SLOT_W   (SLOT_W)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (rd)
	);

	// shared combinational helpers
	logic              exit_ok;
	logic              switch_ok;
	logic              hw_ge2;
	logic [CNT_W-1:0]  idx_inc;
	logic [SLOT_W-1:0] idx_next;
	logic [SLOT_W-1:0] sw_first;
	logic [SLOT_W-1:0] wrap_in;
	logic [CNT_W-1:0]  wrap_inc;
	logic [SLOT_W-1:0] wrap_out;
	logic [CNT_W-1:0]  hw_dec;
	logic [7:0]        tick_inc;
	logic              add_hit;
	logic              sw_hit;
	logic              wait_hit;

	assign exit_ok   = enabled_q && (hw_q != '0) && !kernel_q;
	assign switch_ok = enabled_q && (hw_q != '0);
	assign hw_ge2    = hw_q >= CNT_W'(2);
	assign idx_inc   = {1'b0, scan_idx_q} + CNT_W'(1);
	assign idx_next  = idx_inc[SLOT_W-1:0];
	assign hw_dec    = hw_q - CNT_W'(1);
	assign sw_first  = kernel_q ? hw_dec[SLOT_W-1:0] : cur_q;
	assign tick_inc  = tick_q + 8'd1;

	// round-robin step: next index below high water, wrapping to slot 0
	assign wrap_in  = (state_q == S_SW_CHK) ? scan_idx_q : sw_first;
	assign wrap_inc = {1'b0, wrap_in} + CNT_W'(1);
	assign wrap_out = (wrap_inc >= hw_q) ? '0 : wrap_inc[SLOT_W-1:0];

	assign add_hit  = rd.state == SL_UNUSED;
	assign sw_hit   = rd.state == SL_RUNNABLE;
	assign wait_hit = (rd.pid == pid_q) && (rd.state == SL_ZOMBIE);

	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = scan_idx_q;
		mem_wdata = rd;
		case (state_q)
			S_DISPATCH: begin
				case (op_q)
					OP_ADD: begin
						mem_en   = sp_q != '0;
						mem_addr = '0;
					end
					OP_EXIT: begin
						mem_en   = exit_ok;
						mem_addr = cur_q;
					end
					OP_SWITCH: begin
						mem_en   = switch_ok && !kernel_q;
						mem_addr = cur_q;
					end
					OP_WAIT: begin
						mem_en   = hw_q != '0;
						mem_addr = '0;
					end
					default: begin
						mem_en = 1'b0;
					end
				endcase
			end
			S_ADD_CHK: begin
				if (add_hit) begin
					mem_en    = 1'b1;
					mem_we    = 1'b1;
					mem_wdata = '{state: SL_RUNNABLE, pid: pid_ctr_q, ret_val: '0, sp: sp_q};
				end else if (scan_idx_q != LAST_SLOT) begin
					mem_en   = 1'b1;
					mem_addr = idx_next;
				end
			end
			S_EXIT_WR: begin
				mem_en            = 1'b1;
				mem_we            = 1'b1;
				mem_addr          = cur_q;
				mem_wdata.state   = SL_ZOMBIE;
				mem_wdata.ret_val = code_q;
			end
			S_SAVE_WR: begin
				mem_en       = 1'b1;
				mem_we       = 1'b1;
				mem_addr     = cur_q;
				mem_wdata.sp = sp_q;
			end
			S_SW_DECIDE: begin
				mem_en   = pending_q && (active_q != '0);
				mem_addr = wrap_out;
			end
			S_SW_CHK: begin
				mem_en   = !sw_hit && (scan_cnt_q != hw_q);
				mem_addr = wrap_out;
			end
			S_WAIT_CHK: begin
				if (wait_hit) begin
					mem_en          = 1'b1;
					mem_we          = 1'b1;
					mem_wdata.state = SL_UNUSED;
				end else if (idx_inc != hw_q) begin
					mem_en   = 1'b1;
					mem_addr = idx_next;
				end
			end
			default: begin
				mem_en = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_ADD;
			sp_q       <= '0;
			code_q     <= '0;
			pid_q      <= '0;
			ksp_q      <= '0;
			hw_q       <= '0;
			active_q   <= '0;
			cur_q      <= '0;
			kernel_q   <= 1'b1;
			enabled_q  <= 1'b0;
			pending_q  <= 1'b0;
			pid_ctr_q  <= 16'd1;
			tick_q     <= '0;
			scan_idx_q <= '0;
			scan_cnt_q <= '0;
			done_q     <= 1'b0;
			status_q   <= STAT_OK;
			new_pid_q  <= '0;
			resume_q   <= '0;
			reaped_q   <= '0;
			req_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= operation;
						sp_q    <= stack_pointer;
						code_q  <= exit_value;
						pid_q   <= target_pid;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					status_q   <= STAT_OK;
					new_pid_q  <= '0;
					resume_q   <= sp_q;
					reaped_q   <= '0;
					req_q      <= 1'b0;
					scan_idx_q <= '0;
					state_q    <= S_IDLE;
					done_q     <= 1'b1;
					case (op_q)
						OP_ADD: begin
							if (sp_q == '0) begin
								status_q <= STAT_IGNORED;
							end else begin
								state_q <= S_ADD_CHK;
								done_q  <= 1'b0;
							end
						end
						OP_START: begin
							if (active_q == '0) begin
								status_q <= STAT_NO_TASKS;
							end else begin
								enabled_q <= 1'b1;
								kernel_q  <= 1'b1;
								pending_q <= 1'b1;
								req_q     <= 1'b1;
							end
						end
						OP_TICK: begin
							if (!enabled_q || !hw_ge2) begin
								status_q <= STAT_IGNORED;
							end else if (tick_inc >= period_q) begin
								tick_q    <= '0;
								pending_q <= 1'b1;
							end else begin
								tick_q <= tick_inc;
							end
						end
						OP_YIELD: begin
							if (!enabled_q || !hw_ge2) begin
								status_q <= STAT_IGNORED;
							end else begin
								pending_q <= 1'b1;
								req_q     <= 1'b1;
							end
						end
						OP_EXIT: begin
							if (!exit_ok) begin
								status_q <= STAT_IGNORED;
							end else begin
								state_q <= S_EXIT_WR;
								done_q  <= 1'b0;
							end
						end
						OP_SWITCH: begin
							if (!switch_ok) begin
								status_q <= STAT_IGNORED;
							end else if (!kernel_q) begin
								state_q <= S_SAVE_WR;
								done_q  <= 1'b0;
							end else begin
								ksp_q   <= sp_q;
								state_q <= S_SW_DECIDE;
								done_q  <= 1'b0;
							end
						end
						OP_WAIT: begin
							status_q <= STAT_NOT_FOUND;
							if (hw_q != '0) begin
								state_q <= S_WAIT_CHK;
								done_q  <= 1'b0;
							end
						end
						default: begin
							status_q <= STAT_IGNORED;
						end
					endcase
				end
				S_ADD_CHK: begin
					if (add_hit) begin
						new_pid_q <= pid_ctr_q;
						pid_ctr_q <= pid_ctr_q + 16'd1;
						active_q  <= active_q + CNT_W'(1);
						if (idx_inc > hw_q) begin
							hw_q <= idx_inc;
						end
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else if (scan_idx_q == LAST_SLOT) begin
						status_q <= STAT_NO_FREE;
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
					end else begin
						scan_idx_q <= idx_next;
					end
				end
				S_EXIT_WR: begin
					if (active_q != '0) begin
						active_q <= active_q - CNT_W'(1);
					end
					pending_q <= 1'b1;
					req_q     <= 1'b1;
					state_q   <= S_IDLE;
					done_q    <= 1'b1;
				end
				S_SAVE_WR: begin
					state_q <= S_SW_DECIDE;
				end
				S_SW_DECIDE: begin
					if (!pending_q) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						pending_q <= 1'b0;
						if (active_q == '0) begin
							kernel_q  <= 1'b1;
							enabled_q <= 1'b0;
							resume_q  <= ksp_q;
							state_q   <= S_IDLE;
							done_q    <= 1'b1;
						end else begin
							scan_idx_q <= wrap_out;
							scan_cnt_q <= CNT_W'(1);
							state_q    <= S_SW_CHK;
						end
					end
				end
				S_SW_CHK: begin
					if (sw_hit) begin
						cur_q    <= scan_idx_q;
						kernel_q <= 1'b0;
						resume_q <= rd.sp;
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
					end else if (scan_cnt_q == hw_q) begin
						// nothing runnable: fall back to kernel context
						kernel_q <= 1'b1;
						resume_q <= ksp_q;
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
					end else begin
						scan_idx_q <= wrap_out;
						scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					end
				end
				S_WAIT_CHK: begin
					if (wait_hit) begin
						reaped_q <= rd.ret_val;
						status_q <= STAT_OK;
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
					end else if (idx_inc == hw_q) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						scan_idx_q <= idx_next;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// config register
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= RESCHED_PERIOD_RESET;
		end else if (cfg_wr && (paddr[2] == REG_RESCHED_PERIOD)) begin
			period_q <= pwdata[7:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RESCHED_PERIOD) ? {24'd0, period_q} : '0;

	// outputs
	logic [SLOT_W+1:0] cur_ext;
	assign cur_ext = {2'b00, cur_q};

	assign busy           = state_q != S_IDLE;
	assign done           = done_q;
	assign status         = status_q;
	assign new_pid        = new_pid_q;
	assign resume_pointer = resume_q;
	assign reaped_exit    = reaped_q;
	assign switch_request = req_q;
	assign running_slot   = kernel_q ? 2'b00 : cur_ext[1:0];
	assign in_kernel      = kernel_q;

endmodule

/* rtl/rrs_ram.sv */
module rrs_ram #(
	parameter int WIDTH = 82,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

/* rtl/rrs_slot_table.sv */
module rrs_slot_table #(
	parameter int NUM_SLOTS = 4,
	parameter int SLOT_W    = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                we,
	input  logic [SLOT_W-1:0]   addr,
	input  rrs_pkg::slot_entry_t wdata,
	output rrs_pkg::slot_entry_t rdata
);
	import rrs_pkg::*;

	localparam int EW = $bits(slot_entry_t);

	logic [NUM_SLOTS-1:0] valid_q;
	logic                 rd_valid_q;
	logic [EW-1:0]        ram_rdata;

	rrs_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_SLOTS)
	) u_ram (
		.clk  (clk),
		.en   (en),
		.we   (we),
		.addr (addr),
		.wdata(wdata),
		.rdata(ram_rdata)
	);

	// never-written entries read as unused / zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else if (en) begin
			if (we) begin
				valid_q[addr] <= 1'b1;
			end else begin
				rd_valid_q <= valid_q[addr];
			end
		end
	end

	assign rdata = rd_valid_q ? slot_entry_t'(ram_rdata) : '0;

endmodule

/* rtl/rrs_checker.sv */
module rrs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [2:0]         status,
	input logic [15:0]        new_pid,
	input logic signed [31:0] reaped_exit,
	input logic               switch_request,
	input logic [1:0]         running_slot,
	input logic               in_kernel
);
	import rrs_pkg::*;

	// an accepted word keeps the sequencer busy and gives no result in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted word did not hold busy");

	// a result comes only once the sequencer is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// a failed command gives no pid, reaps nothing and raises no switch request
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STAT_OK)) |-> ((new_pid == 16'd0) && (reaped_exit == 32'sd0)
			&& !switch_request))
		else $error("failed command carried payload");

	// kernel context reports slot zero
	a_kernel_slot: assert property (@(posedge clk) disable iff (!arst_n)
		in_kernel |-> (running_slot == 2'd0))
		else $error("running_slot nonzero in kernel context");

endmodule

bind round_robin_task_scheduler rrs_checker u_rrs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.new_pid       (new_pid),
	.reaped_exit   (reaped_exit),
	.switch_request(switch_request),
	.running_slot  (running_slot),
	.in_kernel     (in_kernel)
);

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import rrs_pkg::*;

	localparam int NUM_SLOTS = 4;
	// op 7 has no meaning; the block must answer it as ignored
	localparam logic [2:0] OP_UNKNOWN = 3'd7;
	// longest stretch with neither a command nor a result word accepted
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] new_pid;
		logic [31:0] resume_pointer;
		logic [31:0] reaped_exit;
		logic        switch_request;
		logic [1:0]  running_slot;
		logic        in_kernel;
	} sched_result_t;

	// ---- DUT connections, all inputs known from time zero ----
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  operation = '0;
	logic [31:0] stack_pointer = '0;
	logic signed [31:0] exit_value = '0;
	logic [15:0] target_pid = '0;
	logic        done;
	logic [2:0]  status;
	logic [15:0] new_pid;
	logic [31:0] resume_pointer;
	logic signed [31:0] reaped_exit;
	logic        switch_request;
	logic [1:0]  running_slot;
	logic        in_kernel;

	round_robin_task_scheduler #(.NUM_SLOTS(NUM_SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .operation(operation),
		.stack_pointer(stack_pointer), .exit_value(exit_value),
		.target_pid(target_pid),
		.done(done), .status(status), .new_pid(new_pid),
		.resume_pointer(resume_pointer), .reaped_exit(reaped_exit),
		.switch_request(switch_request), .running_slot(running_slot),
		.in_kernel(in_kernel)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ---- scheduler shadow state, starts at the reset values ----
	logic [1:0]  slot_st [NUM_SLOTS] = '{default: SL_UNUSED};
	logic [15:0] task_pid [NUM_SLOTS] = '{default: '0};
	logic [31:0] task_exit [NUM_SLOTS] = '{default: '0};
	logic [31:0] task_sp [NUM_SLOTS] = '{default: '0};
	logic [31:0] kernel_sp = '0;
	logic [2:0]  used_limit = '0;     // one past the highest slot ever claimed
	logic [2:0]  live_tasks = '0;
	logic [1:0]  cur_slot = '0;
	logic        kern_now = 1'b1;
	logic        sched_on = 1'b0;
	logic        resched_req = 1'b0;
	logic [15:0] pid_seq = 16'd1;
	logic [7:0]  ticks = '0;
	logic [7:0]  period_cfg = RESCHED_PERIOD_RESET;

	sched_result_t results_due[$];   // one entry per accepted command word
	int errors = 0;
	bit idle_on = 1'b0;
	int quiet_cycles = 0;

	// Apply one command word to the shadow state and return the result word.
	function automatic sched_result_t sched_step(input logic [2:0] op,
			input logic [31:0] sp, input logic [31:0] code, input logic [15:0] pid);
		sched_result_t r;
		int sel;
		int idx;
		bit found;
		r = '0;
		r.resume_pointer = sp;
		found = 1'b0;
		case (op)
			OP_ADD: begin
				sel = NUM_SLOTS;
				for (int i = NUM_SLOTS - 1; i >= 0; i--)
					if (slot_st[i] == SL_UNUSED) sel = i;
				if (sp == '0) begin
					r.status = STAT_IGNORED;
				end else if (sel == NUM_SLOTS) begin
					r.status = STAT_NO_FREE;
				end else begin
					task_sp[sel] = sp;
					task_pid[sel] = pid_seq;
					r.new_pid = pid_seq;
					pid_seq = pid_seq + 16'd1;   // wraps, so pid 0 does come up
					task_exit[sel] = '0;
					slot_st[sel] = SL_RUNNABLE;
					live_tasks = live_tasks + 3'd1;
					if (sel >= used_limit) used_limit = 3'(sel + 1);
				end
			end
			OP_START: begin
				if (live_tasks == 0) begin
					r.status = STAT_NO_TASKS;
				end else begin
					sched_on = 1'b1;
					kern_now = 1'b1;
					resched_req = 1'b1;
					r.switch_request = 1'b1;
				end
			end
			OP_TICK: begin
				if (!sched_on || used_limit < 2) begin
					r.status = STAT_IGNORED;
				end else begin
					ticks = ticks + 8'd1;
					// a period of zero fires on every tick
					if (ticks >= period_cfg) begin
						ticks = '0;
						resched_req = 1'b1;
					end
				end
			end
			OP_YIELD: begin
				if (!sched_on || used_limit < 2) begin
					r.status = STAT_IGNORED;
				end else begin
					resched_req = 1'b1;
					r.switch_request = 1'b1;
				end
			end
			OP_EXIT: begin
				if (!sched_on || used_limit == 0 || kern_now) begin
					r.status = STAT_IGNORED;
				end else begin
					// a zombie or reaped slot may exit again; count saturates
					slot_st[cur_slot] = SL_ZOMBIE;
					task_exit[cur_slot] = code;
					if (live_tasks > 0) live_tasks = live_tasks - 3'd1;
					resched_req = 1'b1;
					r.switch_request = 1'b1;
				end
			end
			OP_SWITCH: begin
				if (!sched_on || used_limit == 0) begin
					r.status = STAT_IGNORED;
				end else begin
					if (!kern_now) task_sp[cur_slot] = sp;
					else kernel_sp = sp;
					if (resched_req) begin
						resched_req = 1'b0;
						if (live_tasks == 0) begin
							// nothing left to run: back to kernel, scheduling off
							kern_now = 1'b1;
							sched_on = 1'b0;
							r.resume_pointer = kernel_sp;
						end else begin
							idx = kern_now ? int'(used_limit) - 1 : int'(cur_slot);
							for (int i = 0; i < used_limit && !found; i++) begin
								idx = idx + 1;
								if (idx >= used_limit) idx = 0;
								if (slot_st[idx] == SL_RUNNABLE) found = 1'b1;
							end
							if (found) begin
								cur_slot = 2'(idx);
								kern_now = 1'b0;
								r.resume_pointer = task_sp[idx];
							end else begin
								kern_now = 1'b1;
								r.resume_pointer = kernel_sp;
							end
						end
					end
				end
			end
			OP_WAIT: begin
				r.status = STAT_NOT_FOUND;
				for (int i = 0; i < used_limit && !found; i++) begin
					if (task_pid[i] == pid && slot_st[i] == SL_ZOMBIE) begin
						r.reaped_exit = task_exit[i];
						slot_st[i] = SL_UNUSED;
						r.status = STAT_OK;
						found = 1'b1;
					end
				end
			end
			default: r.status = STAT_IGNORED;
		endcase
		r.running_slot = kern_now ? 2'd0 : cur_slot;
		r.in_kernel = kern_now;
		return r;
	endfunction

	// ---- result checker: every done word against the oldest expectation ----
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && done) begin
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, actual status %0d",
					$time, status);
			end else begin
				want = results_due.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("new_pid", 32'(want.new_pid), 32'(new_pid));
				check_field("resume_pointer", want.resume_pointer, resume_pointer);
				check_field("reaped_exit", want.reaped_exit, reaped_exit);
				check_field("switch_request", 32'(want.switch_request),
					32'(switch_request));
				check_field("running_slot", 32'(want.running_slot), 32'(running_slot));
				check_field("in_kernel", 32'(want.in_kernel), 32'(in_kernel));
			end
		end
	end

	// watchdog: a run that stops moving words is a failure
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("round_robin_task_scheduler verification failed");
			$finish;
		end
	end

	// ---- stimulus helpers; all called at a falling edge ----

	// Drive one command word and hold it until taken. busy is registered,
	// so low at the falling edge means the next rising edge takes the word.
	// start is left high on return so back-to-back words have no gap.
	task automatic issue_word(input logic [2:0] op, input logic [31:0] sp,
			input logic [31:0] code, input logic [15:0] pid);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		start = 1'b1;
		operation = op;
		stack_pointer = sp;
		exit_value = code;
		target_pid = pid;
		while (busy) @(negedge clk);
		results_due.push_back(sched_step(op, sp, code, pid));
		@(negedge clk);
	endtask

	// stop sending and wait until every expected word has come back
	task automatic drain_results();
		start = 1'b0;
		while (results_due.size() != 0) @(negedge clk);
	endtask

	// register writes only with the block idle
	task automatic set_resched_period(input logic [7:0] value);
		drain_results();
		repeat (8) @(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = 3'(4 * REG_RESCHED_PERIOD);
		pwdata = {24'($urandom), value};   // upper bits are don't-care
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		period_cfg = value;
	endtask

	// ---- tests ----

	// Every op from reset, the ignore paths, full table, double exit, reaping.
	task automatic test_corner_cases();
		issue_word(OP_EXIT, 32'h0, 32'h1, 16'h0);           // disabled
		issue_word(OP_SWITCH, 32'h1234_5678, 32'h0, 16'h0); // disabled, echoed
		issue_word(OP_TICK, 32'h0, 32'h0, 16'h0);
		issue_word(OP_YIELD, 32'h0, 32'h0, 16'h0);
		issue_word(OP_START, 32'h0, 32'h0, 16'h0);          // no tasks yet
		issue_word(OP_WAIT, 32'h0, 32'h0, 16'h0);           // pid absent
		issue_word(OP_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		issue_word(OP_ADD, 32'h0, 32'h0, 16'h0);            // null pointer
		issue_word(OP_ADD, 32'hFFFF_FFFF, 32'h0, 16'h0);
		issue_word(OP_TICK, 32'h0, 32'h0, 16'h0);           // still disabled
		issue_word(OP_START, 32'h0, 32'h0, 16'h0);
		issue_word(OP_EXIT, 32'h0, 32'h5, 16'h0);           // kernel context
		issue_word(OP_TICK, 32'h0, 32'h0, 16'h0);           // one slot only
		issue_word(OP_SWITCH, 32'hA5A5_A5A5, 32'h0, 16'h0); // kernel -> slot 0
		issue_word(OP_ADD, 32'h0000_0001, 32'h0, 16'h0);
		issue_word(OP_ADD, 32'h8000_0000, 32'h0, 16'h0);
		issue_word(OP_ADD, 32'h7FFF_FFFF, 32'h0, 16'h0);
		issue_word(OP_ADD, 32'h0000_5555, 32'h0, 16'h0);    // table full
		issue_word(OP_YIELD, 32'h0, 32'h0, 16'h0);
		issue_word(OP_SWITCH, 32'hDEAD_BEEF, 32'h0, 16'h0); // slot 0 -> 1
		issue_word(OP_EXIT, 32'h0, 32'h8000_0000, 16'h0);
		issue_word(OP_EXIT, 32'h0, 32'h7FFF_FFFF, 16'h0);   // zombie exits again
		issue_word(OP_SWITCH, 32'h0BAD_F00D, 32'h0, 16'h0); // slot 1 -> 2
		issue_word(OP_WAIT, 32'h0, 32'h0, 16'd2);           // reap slot 1
		issue_word(OP_WAIT, 32'h0, 32'h0, 16'd2);           // already reaped
		issue_word(OP_WAIT, 32'h0, 32'h0, 16'd3);           // runnable, not zombie
		issue_word(OP_SWITCH, 32'h0, 32'h0, 16'h0);         // nothing pending
	endtask

	// One running slot exits, is reaped and is claimed again, over and over,
	// while the other slots stay occupied.
	task automatic test_slot_recycle();
		logic [31:0] sp;
		idle_on = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (slot_st[i] == SL_ZOMBIE)
				issue_word(OP_WAIT, 32'h1, 32'h0, task_pid[i]);
		for (int i = 0; i < NUM_SLOTS; i++)
			if (slot_st[i] == SL_UNUSED)
				issue_word(OP_ADD, 32'h1000_0000 + i, 32'h0, 16'h0);
		if (kern_now || !sched_on) begin
			issue_word(OP_START, 32'h0, 32'h0, 16'h0);
			issue_word(OP_SWITCH, 32'hC0DE_0000, 32'h0, 16'h0);
		end
		repeat (20) begin
			sp = $urandom | 32'h1;
			issue_word(OP_EXIT, sp, $urandom, 16'h0);
			issue_word(OP_WAIT, sp, 32'h0, task_pid[cur_slot]);
			issue_word(OP_ADD, sp, 32'h0, 16'h0);
		end
	endtask

	// Random traffic steered by the shadow state so that slots get claimed,
	// scheduled, exited and reaped over and over.
	task automatic test_random_traffic(input logic [7:0] period_val, input int count,
			input bit idle_enable);
		logic [2:0]  op;
		logic [31:0] sp;
		logic [31:0] code;
		logic [15:0] pid;
		int pick;
		set_resched_period(period_val);
		idle_on = idle_enable;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 16) op = OP_ADD;
			else if (pick < 20) op = OP_START;
			else if (pick < 36) op = OP_TICK;
			else if (pick < 44) op = OP_YIELD;
			else if (pick < 54) op = OP_EXIT;
			else if (pick < 78) op = OP_SWITCH;
			else if (pick < 96) op = OP_WAIT;
			else op = OP_UNKNOWN;
			// scheduling drops out when the last task goes; get it back soon
			if (!sched_on && $urandom_range(0, 3) == 0) op = OP_START;
			sp = $urandom;
			if ($urandom_range(0, 19) == 0) sp = 32'h0;
			else if ($urandom_range(0, 19) == 0) sp = 32'hFFFF_FFFF;
			code = $urandom;
			if ($urandom_range(0, 9) == 0)
				code = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			// mostly pids that live in the table, some arbitrary ones
			if ($urandom_range(0, 3) == 0) pid = 16'($urandom);
			else pid = task_pid[$urandom_range(0, NUM_SLOTS - 1)];
			if ($urandom_range(0, 99) == 0) drain_results();
			issue_word(op, sp, code, pid);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		idle_on = 1'b1;
		test_corner_cases();
		test_slot_recycle();
		test_random_traffic(8'd1, 180, 1'b1);
		test_random_traffic(8'd255, 130, 1'b1);
		test_random_traffic(8'd0, 90, 1'b1);
		test_random_traffic(8'($urandom_range(2, 254)), 130, 1'b1);
		// closing stretch runs flat out
		test_random_traffic(RESCHED_PERIOD_RESET, 180, 1'b0);

		drain_results();
		repeat (10) @(negedge clk);
		if (errors == 0) begin
			$display("round_robin_task_scheduler verification clean");
		end else begin
			$display("round_robin_task_scheduler verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/rrs_pkg.sv
rtl/rrs_ram.sv
rtl/rrs_slot_table.sv
rtl/round_robin_task_scheduler.sv
rtl/rrs_checker.sv
verif/testbench.sv
